// ===== design/drf_pkg.sv =====
// Shared types and constants for the duplicate request filter.
// No dependencies; imported by every module of the block except drf_ram.
package drf_pkg;

	// Table size default and register reset values
	localparam int CAPACITY_DEFAULT = 64;
	localparam logic [15:0] EXPIRY_RESET = 16'd30;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY = 8'd1;
	localparam int CFG_DATA_W = 16;

	// Stream widths
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 8;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// One request as it travels through the queue
	typedef struct packed {
		logic        bypass;
		logic [31:0] now;
		logic [31:0] request;
		logic [15:0] port;
		logic [31:0] address;
	} item_t;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] request;
		logic [15:0] port;
		logic [31:0] address;
	} entry_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} back_state_t;

endpackage

// ===== design/duplicate_request_filter.sv =====
// Duplicate request filter: flags repeated requests seen within the expiry window.
// Each request is checked against the N entries stored (up to CAPACITY); a request
// in at-least-once mode skips the scan. One table entry is read per cycle
// from the single RAM read port; the back end starts a request only after the last result.
// Reset: table empty (fill count zero, no clearing pass), mode 0, expiry 30 seconds.
// Depends on drf_pkg, drf_front, drf_back and drf_ram.
module duplicate_request_filter #(
	parameter int CAPACITY = drf_pkg::CAPACITY_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// client_address [31:0], client_port [47:32], request_id [79:48], now_seconds [111:80]
	input  logic [drf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// is_duplicate [0], zero fill [7:1]
	output logic [drf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [drf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [drf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import drf_pkg::*;

	logic        mode_q;
	logic [15:0] expiry_q;
	logic        q_valid;
	logic        q_ready;
	item_t       q_item;
	logic        dup;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			expiry_q <= EXPIRY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_EXPIRY: expiry_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	drf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data (s_axis_tdata),
		.mode    (mode_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	drf_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.expiry   (expiry_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_dup  (dup)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, dup};

endmodule

// ===== design/drf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module drf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/drf_front.sv =====
// Front end: accepts requests, tags them with the filter mode and queues them.
// Depends on drf_pkg.
module drf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [drf_pkg::IN_DATA_W-1:0] in_data,
	input  logic                          mode,
	output logic                          q_valid,
	input  logic                          q_ready,
	output drf_pkg::item_t                q_item
);
	import drf_pkg::*;

	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  fill_q;
	item_t              in_item;
	logic               push;
	logic               pop;

	// unpack the request; at-least-once mode marks it to pass straight through
	always_comb begin
		in_item.address = in_data[31:0];
		in_item.port    = in_data[47:32];
		in_item.request = in_data[79:48];
		in_item.now     = in_data[111:80];
		in_item.bypass  = mode;
	end

	assign in_ready = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ===== design/drf_back.sv =====
// Back end: scans the request table, updates it and drives the result register.
// Depends on drf_pkg and drf_ram.
module drf_back #(
	parameter int CAPACITY = drf_pkg::CAPACITY_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  drf_pkg::item_t q_item,
	input  logic [15:0]    expiry,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_dup
);
	import drf_pkg::*;

	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = $bits(entry_t);

	back_state_t      state_q, state_d;
	item_t            item_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] ptr_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             res_q;
	logic             out_valid_q;
	logic             out_dup_q;

	logic             load_item;
	logic             rd_en;
	logic             insert;
	logic             res_load;
	logic             res_d;
	logic             out_load;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [ENTRY_W-1:0] rdata_raw;
	logic             key_hit;
	logic [31:0]      age;
	logic             live;

	drf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(rdata_raw)
	);

	assign ram_rdata = entry_t'(rdata_raw);

	// compare the entry read last cycle against the current key
	assign key_hit = valid_s1 && (ram_rdata.address == item_q.address) &&
		(ram_rdata.port == item_q.port) && (ram_rdata.request == item_q.request);
	assign age  = item_q.now - ram_rdata.stamp;
	assign live = (age <= {16'b0, expiry});

	// entries only ever hold the current key with the current time
	always_comb begin
		ram_wdata.address = item_q.address;
		ram_wdata.port    = item_q.port;
		ram_wdata.request = item_q.request;
		ram_wdata.stamp   = item_q.now;
	end

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		load_item = 1'b0;
		rd_en     = 1'b0;
		insert    = 1'b0;
		res_load  = 1'b0;
		res_d     = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = oldest_q;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					load_item = 1'b1;
					if (q_item.bypass) begin
						res_load = 1'b1;
						state_d  = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (key_hit) begin
					// live match flags; stale match refreshes the stamp in place
					res_load = 1'b1;
					res_d    = live;
					ram_we   = !live;
					ram_waddr = idx_s1;
					state_d  = ST_DONE;
				end else if (!valid_s1 && (ptr_q >= count_q)) begin
					// every stored entry checked: insert at the replacement pointer
					res_load = 1'b1;
					ram_we   = 1'b1;
					insert   = 1'b1;
					state_d  = ST_DONE;
				end else begin
					rd_en = (ptr_q < count_q);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			oldest_q    <= '0;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			if (load_item) begin
				ptr_q <= '0;
			end else if (rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (insert) begin
				oldest_q <= (oldest_q == IDX_W'(CAPACITY - 1)) ? '0 : oldest_q + 1'b1;
				if (count_q != CNT_W'(CAPACITY)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_item) begin
			item_q <= q_item;
		end
		if (rd_en) begin
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_dup_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_dup   = out_dup_q;

endmodule
